// ===== rtl/tws_pkg.sv =====
// Package for the trie word store: sizes, kind codes, state codes and the
// memory request and status structs. No dependencies.
`default_nettype none

package tws_pkg;

    // Node pool and alphabet
    localparam int NODES      = 1024;
    localparam int ALPHABET   = 26;
    localparam int NODE_W     = $clog2(NODES);
    localparam int USED_W     = $clog2(NODES + 1);
    localparam int LINK_DEPTH = NODES * ALPHABET;
    localparam int LINK_AW    = $clog2(LINK_DEPTH);

    // Fixed field widths
    localparam int KIND_W   = 2;
    localparam int LETTER_W = 5;

    // Operation codes; code 3 behaves as a prefix search
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PREFIX = 2'd2;

    // Sequencer states, one-hot
    typedef enum logic [5:0] {
        ST_CLEAR  = 6'b000001,
        ST_IDLE   = 6'b000010,
        ST_LINK   = 6'b000100,
        ST_FINISH = 6'b001000,
        ST_MARK   = 6'b010000,
        ST_EMIT   = 6'b100000
    } tws_state_t;

    // Child link memory port
    typedef struct packed {
        logic               we;
        logic [LINK_AW-1:0] addr;
        logic [NODE_W-1:0]  wdata;
    } link_req_t;

    // End-of-word mark memory port
    typedef struct packed {
        logic              we;
        logic [NODE_W-1:0] addr;
        logic              wdata;
    } mark_req_t;

    // Status seen by the top level
    typedef struct packed {
        logic              clearing;
        logic [USED_W-1:0] nodes_used;
    } tws_status_t;

    // Slot of a child link: node * ALPHABET + letter
    function automatic logic [LINK_AW-1:0] link_addr(input logic [NODE_W-1:0] node,
                                                    input logic [LETTER_W-1:0] code);
        logic [LINK_AW-1:0] prod;
        prod = LINK_AW'(node) * LINK_AW'(ALPHABET);
        return prod + LINK_AW'(code);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/tws_ram.sv =====
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module tws_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write, with the read data registered
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

// ===== rtl/tws_walker.sv =====
// Sequencer of the trie word store: clearing pass, cursor walk, node
// allocation, result logic and output register. Uses tws_pkg.
`default_nettype none

module tws_walker (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [tws_pkg::KIND_W-1:0]   s_kind,
    input  wire logic [tws_pkg::LETTER_W-1:0] s_letter,
    input  wire logic                         s_has_letter,
    input  wire logic                         s_last,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic                              m_found,
    output logic                              m_status,
    output tws_pkg::link_req_t                link_req,
    input  wire logic [tws_pkg::NODE_W-1:0]   link_rdata,
    output tws_pkg::mark_req_t                mark_req,
    input  wire logic                         mark_rdata,
    output tws_pkg::tws_status_t              status
);
    import tws_pkg::*;

    tws_state_t          state_reg, state_next;
    logic [LINK_AW-1:0]  clr_idx_reg, clr_idx_next;
    logic [NODE_W-1:0]   cursor_reg, cursor_next;
    logic                broken_reg, broken_next;
    logic [USED_W-1:0]   used_reg, used_next;
    logic [KIND_W-1:0]   kind_reg, kind_next;
    logic                last_reg, last_next;
    logic [LINK_AW-1:0]  slot_reg, slot_next;
    logic                res_found_reg, res_found_next;
    logic                res_status_reg, res_status_next;
    logic                m_valid_reg, m_valid_next;
    logic                m_found_reg, m_found_next;
    logic                m_status_reg, m_status_next;

    logic                letter_ok;
    logic                walk;
    logic [LINK_AW-1:0]  in_slot;

    assign letter_ok = (32'(s_letter) < 32'(ALPHABET));
    assign walk      = s_has_letter && letter_ok && !broken_reg;
    assign in_slot   = link_addr(cursor_reg, s_letter);

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_found  = m_found_reg;
    assign m_status = m_status_reg;

    assign status.clearing   = (state_reg == ST_CLEAR);
    assign status.nodes_used = used_reg;

    // Next-state logic and memory requests
    always_comb begin
        state_next      = state_reg;
        clr_idx_next    = clr_idx_reg;
        cursor_next     = cursor_reg;
        broken_next     = broken_reg;
        used_next       = used_reg;
        kind_next       = kind_reg;
        last_next       = last_reg;
        slot_next       = slot_reg;
        res_found_next  = res_found_reg;
        res_status_next = res_status_reg;
        m_valid_next    = m_valid_reg;
        m_found_next    = m_found_reg;
        m_status_next   = m_status_reg;

        link_req.we    = 1'b0;
        link_req.addr  = slot_reg;
        link_req.wdata = '0;
        mark_req.we    = 1'b0;
        mark_req.addr  = cursor_reg;
        mark_req.wdata = 1'b0;

        // Output register drains independently
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR: begin
                // Zero every link, and every mark in the low part of the sweep
                link_req.we   = 1'b1;
                link_req.addr = clr_idx_reg;
                mark_req.addr = clr_idx_reg[NODE_W-1:0];
                mark_req.we   = (clr_idx_reg < LINK_AW'(NODES));
                clr_idx_next  = clr_idx_reg + 1'b1;
                if (clr_idx_reg == LINK_AW'(LINK_DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                // Take a transaction; a walking letter reads its child link
                link_req.addr = in_slot;
                if (s_valid) begin
                    kind_next = s_kind;
                    last_next = s_last;
                    slot_next = in_slot;
                    if (walk) begin
                        state_next = ST_LINK;
                    end else if (s_last) begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_LINK: begin
                // Follow the child, grow a node on insert, or break the path
                if (link_rdata != '0) begin
                    cursor_next = link_rdata;
                end else if (kind_reg == KIND_INSERT && used_reg < USED_W'(NODES)) begin
                    link_req.we    = 1'b1;
                    link_req.wdata = used_reg[NODE_W-1:0];
                    cursor_next    = used_reg[NODE_W-1:0];
                    used_next      = used_reg + 1'b1;
                end else begin
                    broken_next = 1'b1;
                end
                state_next = last_reg ? ST_FINISH : ST_IDLE;
            end
            ST_FINISH: begin
                res_status_next = 1'b0;
                state_next      = ST_EMIT;
                case (kind_reg)
                    KIND_INSERT: begin
                        if (broken_reg) begin
                            res_found_next  = 1'b0;
                            res_status_next = 1'b1;
                        end else begin
                            mark_req.we    = 1'b1;
                            mark_req.wdata = 1'b1;
                            res_found_next = 1'b1;
                        end
                    end
                    KIND_SEARCH: begin
                        // Intact path: read the mark of the cursor node
                        res_found_next = 1'b0;
                        if (!broken_reg) begin
                            state_next = ST_MARK;
                        end
                    end
                    default: begin
                        res_found_next = !broken_reg;
                    end
                endcase
            end
            ST_MARK: begin
                res_found_next = mark_rdata;
                state_next     = ST_EMIT;
            end
            ST_EMIT: begin
                // Load the result once the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_found_next  = res_found_reg;
                    m_status_next = res_status_reg;
                    cursor_next   = '0;
                    broken_next   = 1'b0;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_idx_reg <= '0;
            cursor_reg  <= '0;
            broken_reg  <= 1'b0;
            used_reg    <= USED_W'(1);
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_idx_reg <= clr_idx_next;
            cursor_reg  <= cursor_next;
            broken_reg  <= broken_next;
            used_reg    <= used_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        kind_reg       <= kind_next;
        last_reg       <= last_next;
        slot_reg       <= slot_next;
        res_found_reg  <= res_found_next;
        res_status_reg <= res_status_next;
        m_found_reg    <= m_found_next;
        m_status_reg   <= m_status_next;
    end

endmodule

`default_nettype wire

// ===== rtl/trie_word_store_unit.sv =====
// Trie word store. A letter transaction is accepted, then its child link is read from
// the RAM with registered read data and sets the next cursor. A word's last
// transaction then passes through finish, a mark read for an exact search, and
// result load; it waits in result load while the output register is full and m_ready
// is low. After reset a clearing pass zeroes all 26624 link entries and the marks,
// one per cycle, with s_ready low. Uses tws_pkg, tws_ram and tws_walker.
`default_nettype none

module trie_word_store_unit (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [tws_pkg::KIND_W-1:0]   s_kind,
    input  wire logic [tws_pkg::LETTER_W-1:0] s_letter,
    input  wire logic                         s_has_letter,
    input  wire logic                         s_last,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic                              m_found,
    output logic                              m_status
);
    import tws_pkg::*;

    link_req_t          link_req;
    mark_req_t          mark_req;
    logic [NODE_W-1:0]  link_rdata;
    logic               mark_rdata;
    tws_status_t        status;

    // Child links, one entry per node and letter
    tws_ram #(
        .WIDTH (NODE_W),
        .DEPTH (LINK_DEPTH)
    ) u_link_ram (
        .aclk  (aclk),
        .we    (link_req.we),
        .addr  (link_req.addr),
        .wdata (link_req.wdata),
        .rdata (link_rdata)
    );

    // End-of-word marks, one per node
    tws_ram #(
        .WIDTH (1),
        .DEPTH (NODES)
    ) u_mark_ram (
        .aclk  (aclk),
        .we    (mark_req.we),
        .addr  (mark_req.addr),
        .wdata (mark_req.wdata),
        .rdata (mark_rdata)
    );

    // Sequencer
    tws_walker u_walker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_kind       (s_kind),
        .s_letter     (s_letter),
        .s_has_letter (s_has_letter),
        .s_last       (s_last),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_found      (m_found),
        .m_status     (m_status),
        .link_req     (link_req),
        .link_rdata   (link_rdata),
        .mark_req     (mark_req),
        .mark_rdata   (mark_rdata),
        .status       (status)
    );

`ifndef SYNTHESIS
    // No transaction is taken during the clearing pass
    a_no_accept_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        status.clearing |-> !s_ready)
        else $error("input taken during clearing pass");

    // Pool exhausted never reports a stored word
    a_status_not_found: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status) |-> !m_found)
        else $error("pool-full result reports found");

    // A link written outside the clearing pass points at a real child
    a_link_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (link_req.we && !status.clearing) |-> (link_req.wdata != '0))
        else $error("link write of the root outside clearing");

    // Allocation grows the pool by one and never past its size
    a_pool_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (link_req.we && !status.clearing) |=>
            (status.nodes_used == $past(status.nodes_used) + 1'b1) &&
            (status.nodes_used <= USED_W'(NODES)))
        else $error("node pool count broken");
`endif

endmodule

`default_nettype wire
